[src/ts_ups_pkg.sv]
// Shared types, widths and helpers for the time slot upsampler.
`timescale 1ns / 1ps
`default_nettype none

package ts_ups_pkg;

    localparam int TIME_W   = 60;
    localparam int EXP_W    = 40;
    localparam int IVL_W    = 40;
    localparam int TAG_W    = 16;
    localparam int STEP_W   = 5;
    localparam int IDX_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW   = 40;
    localparam int MAX_STEP = 16;
    localparam int ACC_W    = TIME_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_TIMESTEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_IVL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_IVL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_TOL  = 2'd3;

    localparam logic [STEP_W-1:0] TIMESTEP_RST = STEP_W'(2);

    // input word command
    typedef enum logic {
        CMD_SLOT   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_INIT,
        ST_SCAN,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic              start;
        logic [EXP_W-1:0]  dividend;
        logic [STEP_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic [EXP_W-1:0] quot;
    } t_div_rsp;

    // Sub-slots per slot: zero reads as one, anything past the bound is clamped.
    function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] ts);
        logic [STEP_W-1:0] s;
        s = ts;
        if (ts == '0) begin
            s = STEP_W'(1);
        end else if (ts > STEP_W'(MAX_STEP)) begin
            s = STEP_W'(MAX_STEP);
        end
        return s;
    endfunction

    // Clamp an unsaturated time accumulator to the 60-bit time range.
    function automatic logic [TIME_W-1:0] sat_time(input logic [ACC_W-1:0] acc);
        return acc[ACC_W-1] ? TIME_MAX : acc[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/time_slot_upsampler.sv]
// Top level of the time slot upsampler: sequencer, held slot state and output stage.
`timescale 1ns / 1ps
`default_nettype none

// Splits each incoming time slot into timestep sub-slots and releases the
// sub-slots of the previous slot when the next one arrives (or on a finish
// word). Times are unsigned ticks of 2^-20 s. One word is processed at a time;
// the input is not ready while the sequencer runs. For a new-slot word the
// sub-exposure comes from a bit-serial divider, one bit per cycle over 40
// bits, while the flush scan steps past, compares or emits the held
// sub-slots; the new slot is taken over only once the divide is done.
// A finish word emits every held sub-slot not yet emitted, then clears
// the held slot.
// Back-pressure on the output stalls the scan. Results go through an output
// register with one pending stage behind it, so o_last can be set on the
// final result of each input word; the next input word is taken while the
// last result still waits in the output register. Configuration writes are
// expected only while the block is idle.
module time_slot_upsampler
    import ts_ups_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    // input words
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_cmd,
    input  wire logic [TIME_W-1:0]    i_slot_time,
    input  wire logic [EXP_W-1:0]     i_exposure,
    input  wire logic                 i_all_flagged,
    input  wire logic [TAG_W-1:0]     i_slot_tag,
    // result words
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [TAG_W-1:0]          o_src_tag,
    output logic [IDX_W-1:0]          o_sub_index,
    output logic [TIME_W-1:0]         o_sub_time,
    output logic [EXP_W-1:0]          o_sub_exposure,
    output logic                      o_last
);

    // configuration
    logic [STEP_W-1:0] r_timestep;
    logic [IVL_W-1:0]  r_slot_ivl;
    logic [IVL_W-1:0]  r_sub_ivl;
    logic [IVL_W-1:0]  r_near_tol;

    t_state r_state, n_state;

    // held slot
    logic              r_hv, n_hv;
    logic [TAG_W-1:0]  r_htag, n_htag;
    logic [TIME_W-1:0] r_hstart, n_hstart;
    logic [EXP_W-1:0]  r_hexp, n_hexp;
    logic [STEP_W-1:0] r_ftf, n_ftf;

    // captured input word
    logic              r_fin, n_fin;
    logic [TIME_W-1:0] r_time, n_time;
    logic              r_flag, n_flag;
    logic [TAG_W-1:0]  r_tag, n_tag;

    // scan working state
    logic [TIME_W-1:0] r_nstart, n_nstart;
    logic [ACC_W-1:0]  r_pacc, n_pacc;   // held sub-slot time, unsaturated
    logic [ACC_W-1:0]  r_nacc, n_nacc;   // new sub-slot time, unsaturated
    logic [STEP_W-1:0] r_p, n_p;
    logic [STEP_W-1:0] r_c, n_c;
    logic [STEP_W-1:0] r_ftf_new, n_ftf_new;
    logic              r_stop, n_stop;

    // pending result (one behind the output register)
    logic              r_pd_v, n_pd_v;
    logic [IDX_W-1:0]  r_pd_idx, n_pd_idx;
    logic [TIME_W-1:0] r_pd_time, n_pd_time;

    // output register
    logic              r_ov, n_ov;
    logic [TAG_W-1:0]  r_o_tag, n_o_tag;
    logic [IDX_W-1:0]  r_o_idx, n_o_idx;
    logic [TIME_W-1:0] r_o_time, n_o_time;
    logic [EXP_W-1:0]  r_o_exp, n_o_exp;
    logic              r_o_last, n_o_last;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] half_slot;
    logic [ACC_W-1:0]  sub61;
    logic [ACC_W-1:0]  half_sub61;
    logic [TIME_W-1:0] pt, nt;
    logic [TIME_W:0]   d_pn;
    logic [TIME_W-1:0] d_abs;
    logic              gt, is_near, c_ok;
    logic              out_free, emit_req, emit_ok, push_last;
    logic              in_acc;

    assign step       = eff_step(r_timestep);
    assign half_slot  = TIME_W'(r_slot_ivl >> 1);
    assign sub61      = ACC_W'(r_sub_ivl);
    assign half_sub61 = ACC_W'(r_sub_ivl >> 1);
    assign in_acc     = i_in_valid && o_in_ready;

    // Shared compare unit: held sub-slot time against new sub-slot time.
    assign pt      = sat_time(r_pacc);
    assign nt      = sat_time(r_nacc);
    assign d_pn    = {1'b0, pt} - {1'b0, nt};
    assign d_abs   = d_pn[TIME_W] ? (nt - pt) : d_pn[TIME_W-1:0];
    assign gt      = !d_pn[TIME_W] && (d_pn != '0);
    assign is_near = d_abs <= TIME_W'(r_near_tol);
    assign c_ok    = r_c < step;

    assign out_free = !r_ov || i_out_ready;
    assign emit_ok  = !r_pd_v || out_free;

    assign div_req.start    = in_acc && (i_cmd == CMD_SLOT);
    assign div_req.dividend = i_exposure;
    assign div_req.divisor  = step;

    ts_ups_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_hv      = r_hv;
        n_htag    = r_htag;
        n_hstart  = r_hstart;
        n_hexp    = r_hexp;
        n_ftf     = r_ftf;
        n_fin     = r_fin;
        n_time    = r_time;
        n_flag    = r_flag;
        n_tag     = r_tag;
        n_nstart  = r_nstart;
        n_pacc    = r_pacc;
        n_nacc    = r_nacc;
        n_p       = r_p;
        n_c       = r_c;
        n_ftf_new = r_ftf_new;
        n_stop    = r_stop;
        n_pd_v    = r_pd_v;
        n_pd_idx  = r_pd_idx;
        n_pd_time = r_pd_time;
        n_ov      = r_ov && !i_out_ready;
        n_o_tag   = r_o_tag;
        n_o_idx   = r_o_idx;
        n_o_time  = r_o_time;
        n_o_exp   = r_o_exp;
        n_o_last  = r_o_last;
        emit_req  = 1'b0;
        push_last = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_fin   = (i_cmd == CMD_FINISH);
                    n_time  = i_slot_time;
                    n_flag  = i_all_flagged;
                    n_tag   = i_slot_tag;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                // start of the new slot, floored at zero
                n_nstart = (r_time > half_slot) ? (r_time - half_slot) : '0;
                n_state  = ST_INIT;
            end
            ST_INIT: begin
                n_pacc    = ACC_W'(r_hstart) + half_sub61;
                n_nacc    = ACC_W'(r_nstart) + half_sub61;
                n_p       = '0;
                n_c       = '0;
                n_ftf_new = r_ftf;
                n_stop    = 1'b0;
                n_state   = r_hv ? ST_SCAN : ST_FINAL;
            end
            ST_SCAN: begin
                if (r_stop || r_p >= step) begin
                    n_state = ST_FINAL;
                end else if (r_p < r_ftf) begin
                    // already emitted earlier: step past it
                    n_p    = r_p + STEP_W'(1);
                    n_pacc = r_pacc + sub61;
                end else if (!r_fin && c_ok && gt && !is_near) begin
                    n_c    = r_c + STEP_W'(1);
                    n_nacc = r_nacc + sub61;
                end else if (!r_fin && c_ok && is_near && !r_flag) begin
                    // duplicate replaced by the new slot: flush ends here
                    n_stop    = 1'b1;
                    n_ftf_new = '0;
                end else begin
                    emit_req = 1'b1;
                    if (emit_ok) begin
                        n_p       = r_p + STEP_W'(1);
                        n_pacc    = r_pacc + sub61;
                        n_ftf_new = (!r_fin && c_ok && is_near) ?
                                    (r_c + STEP_W'(1)) : '0;
                    end
                end
            end
            ST_FINAL: begin
                if (r_pd_v) begin
                    push_last = out_free;
                end else if (r_fin) begin
                    n_hv    = 1'b0;
                    n_htag  = '0;
                    n_hstart = '0;
                    n_hexp  = '0;
                    n_ftf   = '0;
                    n_state = ST_IDLE;
                end else if (!div_rsp.busy) begin
                    n_hv     = 1'b1;
                    n_htag   = r_tag;
                    n_hstart = r_nstart;
                    n_hexp   = div_rsp.quot;
                    n_ftf    = r_ftf_new;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // pending stage -> output register; new result -> pending stage
        if ((emit_req && emit_ok && r_pd_v) || push_last) begin
            n_ov     = 1'b1;
            n_o_tag  = r_htag;
            n_o_idx  = r_pd_idx;
            n_o_time = r_pd_time;
            n_o_exp  = r_hexp;
            n_o_last = push_last;
        end
        if (push_last) begin
            n_pd_v = 1'b0;
        end
        if (emit_req && emit_ok) begin
            n_pd_v    = 1'b1;
            n_pd_idx  = r_p[IDX_W-1:0];
            n_pd_time = pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timestep <= TIMESTEP_RST;
            r_slot_ivl <= '0;
            r_sub_ivl  <= '0;
            r_near_tol <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIMESTEP: r_timestep <= i_cfg_data[STEP_W-1:0];
                CFG_SLOT_IVL: r_slot_ivl <= i_cfg_data[IVL_W-1:0];
                CFG_SUB_IVL:  r_sub_ivl  <= i_cfg_data[IVL_W-1:0];
                CFG_NEAR_TOL: r_near_tol <= i_cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= 1'b0;
            r_ftf  <= '0;
            r_pd_v <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_hv   <= n_hv;
            r_ftf  <= n_ftf;
            r_pd_v <= n_pd_v;
            r_ov   <= n_ov;
        end
        r_htag    <= n_htag;
        r_hstart  <= n_hstart;
        r_hexp    <= n_hexp;
        r_fin     <= n_fin;
        r_time    <= n_time;
        r_flag    <= n_flag;
        r_tag     <= n_tag;
        r_nstart  <= n_nstart;
        r_pacc    <= n_pacc;
        r_nacc    <= n_nacc;
        r_p       <= n_p;
        r_c       <= n_c;
        r_ftf_new <= n_ftf_new;
        r_stop    <= n_stop;
        r_pd_idx  <= n_pd_idx;
        r_pd_time <= n_pd_time;
        r_o_tag   <= n_o_tag;
        r_o_idx   <= n_o_idx;
        r_o_time  <= n_o_time;
        r_o_exp   <= n_o_exp;
        r_o_last  <= n_o_last;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_ov;
    assign o_src_tag      = r_o_tag;
    assign o_sub_index    = r_o_idx;
    assign o_sub_time     = r_o_time;
    assign o_sub_exposure = r_o_exp;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

[src/ts_ups_div.sv]
// Bit-serial restoring divider: exposure by sub-slot count, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module ts_ups_div
    import ts_ups_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int CNT_W = $clog2(EXP_W);

    logic              r_busy, n_busy;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [EXP_W-1:0]  r_q, n_q;
    logic [STEP_W-1:0] r_r, n_r;
    logic [STEP_W-1:0] r_d, n_d;
    logic [STEP_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        trial  = {r_r, r_q[EXP_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_d}) begin
                n_r = STEP_W'(trial - {1'b0, r_d});
                n_q = {r_q[EXP_W-2:0], 1'b1};
            end else begin
                n_r = trial[STEP_W-1:0];
                n_q = {r_q[EXP_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(EXP_W - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_r   <= n_r;
        r_d   <= n_d;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_q;

endmodule

`default_nettype wire
